>>> hw/rtl/lprf_pkg.sv
// lprf_pkg: shared types and constants of the LRU page frame replacer.
// Used by lprf_ctrl, lprf_dp and lru_page_frame_replacer; depends on nothing.
`default_nettype none

package lprf_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS      = 20;
    localparam int PID_BITS       = 8;
    localparam int CFG_BITS       = 5;
    localparam int USE_BITS       = 16;
    localparam int TOTAL_BITS     = 32;
    localparam int PROC_BITS      = 16;
    localparam int IDX_OUT_BITS   = 4;

    localparam logic [CFG_BITS-1:0] FRAMES_IN_USE_RST = 5'd16;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page_number;
        logic [PID_BITS-1:0]  process_id;
        logic                 first_of_process;
    } in_item_t;

    typedef struct packed {
        logic                    hit;
        logic [IDX_OUT_BITS-1:0] frame_index;
        logic [TOTAL_BITS-1:0]   total_faults;
        logic [PROC_BITS-1:0]    process_faults;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic lookup;
        logic commit;
    } dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/lru_page_frame_replacer.sv
// lru_page_frame_replacer: top level of the LRU page frame replacer.
// Depends on lprf_pkg, lprf_ctrl and lprf_dp.
//
// Usage:
//   Input: drive item and raise start; the item is taken at a clock edge
//   where start is high and busy is low. busy is high for one cycle after
//   each accepted item.
//   Output: done pulses for one cycle with result holding hit, frame index
//   and both fault counts. The receiver has no way to hold results off.
//   Config: wr_en with wr_data writes frames_in_use (reset value 16); write
//   only while no item is in flight.
// Timing:
//   The frame table match and victim pick happen in the accept cycle, the
//   recency list and counters are updated in the following cycle, and done
//   rises in the cycle after that. A new item is not taken while the
//   controller is in its update step, so items go through the lookup and
//   update steps one at a time.
// Reset:
//   All frames invalid, recency list 0 to MAX_FRAMES-1, counters zero.
`default_nettype none

module lru_page_frame_replacer #(
    parameter int MAX_FRAMES = lprf_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire lprf_pkg::in_item_t              item,
    output logic                                 done,
    output lprf_pkg::result_t                    result,
    input  wire logic                            wr_en,
    input  wire logic [lprf_pkg::CFG_BITS-1:0]   wr_data
);

    lprf_pkg::dp_cmd_t cmd;

    lprf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    lprf_dp #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item    (item),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .result  (result)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter update");

    a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("update step did not finish in one cycle");

    a_done_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.commit))
        else $error("result strobe without commit");

    a_fault_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.total_faults != '0))
        else $error("fault reported with zero total count");

endmodule

`default_nettype wire

>>> hw/rtl/lprf_ctrl.sv
// lprf_ctrl: controller of the replacer; sequences lookup and commit.
// Depends on lprf_pkg.
`default_nettype none

module lprf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output lprf_pkg::dp_cmd_t      cmd
);

    lprf_pkg::state_t state_reg;
    lprf_pkg::state_t state_next;
    logic             done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lprf_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.commit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.lookup = 1'b0;
        cmd.commit = 1'b0;
        busy       = 1'b0;
        case (state_reg)
            lprf_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.lookup = 1'b1;
                    state_next = lprf_pkg::ST_UPDATE;
                end
            end
            lprf_pkg::ST_UPDATE:
            begin
                busy       = 1'b1;
                cmd.commit = 1'b1;
                state_next = lprf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lprf_pkg::ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/lprf_dp.sv
// lprf_dp: datapath of the replacer: frame CAM, recency list, use-count and
// owner memories, fault counters, result register. Depends on lprf_pkg.
`default_nettype none

module lprf_dp #(
    parameter int MAX_FRAMES = lprf_pkg::MAX_FRAMES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lprf_pkg::dp_cmd_t               cmd,
    input  wire lprf_pkg::in_item_t              item,
    input  wire logic                            wr_en,
    input  wire logic [lprf_pkg::CFG_BITS-1:0]   wr_data,
    output lprf_pkg::result_t                    result
);

    localparam int FW   = $clog2(MAX_FRAMES);
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int CMPW = (CW > lprf_pkg::CFG_BITS) ? CW : lprf_pkg::CFG_BITS;
    localparam int PB   = lprf_pkg::PAGE_BITS;
    localparam int UB   = lprf_pkg::USE_BITS;
    localparam int TB   = lprf_pkg::TOTAL_BITS;
    localparam int QB   = lprf_pkg::PROC_BITS;

    // configuration and control state
    logic [lprf_pkg::CFG_BITS-1:0] fiu_reg;
    logic [MAX_FRAMES-1:0]         valid_reg;
    logic [FW-1:0]                 order_reg [MAX_FRAMES];
    logic [TB-1:0]                 total_reg;
    logic [QB-1:0]                 proc_reg;

    // payload
    logic [PB-1:0]                 page_reg [MAX_FRAMES];
    logic [UB-1:0]                 use_mem [MAX_FRAMES];
    logic [lprf_pkg::PID_BITS-1:0] owner_mem [MAX_FRAMES];
    logic [UB-1:0]                 use_rd_reg;
    logic                          hit_reg;
    logic [FW-1:0]                 frame_reg;
    logic [PB-1:0]                 page_in_reg;
    logic [lprf_pkg::PID_BITS-1:0] pid_reg;
    logic                          first_reg;
    lprf_pkg::result_t             result_reg;

    // lookup
    logic [CMPW-1:0]       fiu_ext;
    logic [CMPW-1:0]       n_act;
    logic [MAX_FRAMES-1:0] match_vec;
    logic [MAX_FRAMES-1:0] elig_vec;
    logic [FW-1:0]         match_idx;
    logic [FW-1:0]         victim;
    logic [FW-1:0]         sel_frame;

    // update
    logic [MAX_FRAMES-1:0] sel_pos;
    logic [MAX_FRAMES-1:0] shift_mask;
    logic [FW-1:0]         order_next [MAX_FRAMES];
    logic [QB-1:0]         proc_base;
    logic [QB-1:0]         proc_new;
    logic [TB-1:0]         total_new;
    logic [UB-1:0]         use_new;
    logic [FW+3:0]         frame_ext;

    assign fiu_ext = CMPW'(fiu_reg);

    always_comb
    begin
        if (fiu_ext == '0)
            n_act = CMPW'(1);
        else if (fiu_ext > CMPW'(MAX_FRAMES))
            n_act = CMPW'(MAX_FRAMES);
        else
            n_act = fiu_ext;
    end

    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_row
        assign match_vec[i] = valid_reg[i] && (page_reg[i] == item.page_number)
                              && (CMPW'(i) < n_act);
        assign elig_vec[i]  = CMPW'(order_reg[i]) < n_act;
        assign sel_pos[i]   = order_reg[i] == frame_reg;
        if (i == 0)
        begin : g_first
            assign shift_mask[i] = sel_pos[i];
        end
        else
        begin : g_rest
            assign shift_mask[i] = shift_mask[i-1] | sel_pos[i];
        end
        if (i == MAX_FRAMES - 1)
        begin : g_last
            assign order_next[i] = shift_mask[i] ? frame_reg : order_reg[i];
        end
        else
        begin : g_mid
            assign order_next[i] = shift_mask[i] ? order_reg[i+1] : order_reg[i];
        end
    end

    // lowest matching frame and least recent eligible frame
    always_comb
    begin
        match_idx = '0;
        victim    = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
                match_idx = FW'(i);
            if (elig_vec[i])
                victim = order_reg[i];
        end
    end

    assign sel_frame = (|match_vec) ? match_idx : victim;

    assign proc_base = first_reg ? '0 : proc_reg;
    assign proc_new  = (hit_reg || (&proc_base)) ? proc_base : proc_base + QB'(1);
    assign total_new = (hit_reg || (&total_reg)) ? total_reg : total_reg + TB'(1);
    assign use_new   = (&use_rd_reg) ? use_rd_reg : use_rd_reg + UB'(1);
    assign frame_ext = {4'b0, frame_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg   <= lprf_pkg::FRAMES_IN_USE_RST;
            valid_reg <= '0;
            total_reg <= '0;
            proc_reg  <= '0;
            for (int i = 0; i < MAX_FRAMES; i++)
                order_reg[i] <= FW'(i);
        end
        else
        begin
            if (wr_en)
                fiu_reg <= wr_data;
            if (cmd.commit)
            begin
                total_reg <= total_new;
                proc_reg  <= proc_new;
                for (int i = 0; i < MAX_FRAMES; i++)
                    order_reg[i] <= order_next[i];
                if (!hit_reg)
                    valid_reg[frame_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            hit_reg     <= |match_vec;
            frame_reg   <= sel_frame;
            page_in_reg <= item.page_number;
            pid_reg     <= item.process_id;
            first_reg   <= item.first_of_process;
            use_rd_reg  <= use_mem[match_idx];
        end
        if (cmd.commit)
        begin
            if (hit_reg)
            begin
                use_mem[frame_reg] <= use_new;
            end
            else
            begin
                page_reg[frame_reg]  <= page_in_reg;
                owner_mem[frame_reg] <= pid_reg;
                // first fill of a frame starts its use count at zero
                if (!valid_reg[frame_reg])
                    use_mem[frame_reg] <= '0;
            end
            result_reg.hit            <= hit_reg;
            result_reg.frame_index    <= frame_ext[3:0];
            result_reg.total_faults   <= total_new;
            result_reg.process_faults <= proc_new;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
